// File: src/single_frequency_filter_envelope_defines.svh
// Assertion macros for the single-frequency filter envelope block.
// No dependencies; included by the top level.
`ifndef SINGLE_FREQUENCY_FILTER_ENVELOPE_DEFINES_SVH
`define SINGLE_FREQUENCY_FILTER_ENVELOPE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SFFE_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: assertion failed");
`define SFFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`else
`define SFFE_ASSERT_NEVER(label, clk, rst_n, expr)
`define SFFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/sffe_pkg.sv
// Shared constants, types and the quarter-wave sine table.
// No dependencies; imported by all modules of the envelope block.
package sffe_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int FRACTION_BITS   = 15;

    localparam int SAMPLE_W  = 16;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PHASE_W   = 32;
    localparam int RADIUS_W  = 15;
    localparam int FILT_W    = 40;
    localparam int HALF_W    = FILT_W / 2;
    localparam int SQ_W      = 2 * FILT_W;
    localparam int ENV_W     = 25;
    localparam int Z_W       = 2 * ENV_W;
    localparam int REM_W     = ENV_W + 2;
    localparam int ROOT_CNT_W = $clog2(ENV_W);

    localparam int QTR_N     = 2 ** (SINE_TABLE_BITS - 2);
    localparam int QTR_IDX_W = SINE_TABLE_BITS - 1;

    // multiplier: A takes 20-bit halves and |x|, B also the sine magnitude
    localparam int MUL_B_W = (FRACTION_BITS + 1 > HALF_W) ? FRACTION_BITS + 1 : HALF_W;
    localparam int PROD_W  = HALF_W + MUL_B_W;

    localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLE_RADIUS = 1'b1;

    localparam logic [PHASE_W-1:0]  PHASE_STEP_RST  = 32'd858993459;
    localparam logic [RADIUS_W-1:0] POLE_RADIUS_RST = 15'd32440;

    localparam int WQ_DEPTH = 4;
    localparam int WQ_PTR_W = $clog2(WQ_DEPTH);

    localparam logic [63:0] PI_Q30 = 64'hC90FDAA2;

    typedef logic [FRACTION_BITS:0] t_qval;
    typedef t_qval t_qtab [0:QTR_N];

    // one request handed from front to back; index 0 is cos, 1 is sin
    typedef struct packed {
        logic                   start;
        logic                   x_neg;
        logic [DIFF_W-1:0]      x_mag;
        logic [1:0]             coef_neg;
        t_qval [1:0]            coef_mag;
    } t_work;

    typedef struct packed {
        logic wq_pop;
        logic res_load;
    } t_back_stat;

    // Taylor series in Q30, rounded to QF
    function automatic t_qval quarter_sine(logic [31:0] i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        x    = (PI_Q30 * 64'd2 * 64'(i)) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        rounded = ($unsigned(sum) + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
        return rounded[FRACTION_BITS:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int i = 0; i <= QTR_N; i++) begin
            tab[i] = quarter_sine(32'(i));
        end
        return tab;
    endfunction

    localparam t_qtab QUARTER_TAB = build_qtab();

endpackage

// File: src/sffe_front.sv
// Front end: sample differencing, phase accumulator and sine/cos lookup.
// Depends on sffe_pkg; feeds sffe_queue.
module sffe_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sffe_pkg::PHASE_W-1:0]  i_phase_step,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [sffe_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_start_req,
    input  logic                          i_wq_full,
    output logic                          o_wq_wr,
    output sffe_pkg::t_work               o_wq_data
);
    import sffe_pkg::*;

    logic                       r_valid;
    logic                       r_start;
    logic                       r_x_neg;
    logic [DIFF_W-1:0]          r_x_mag;
    logic [SINE_TABLE_BITS-1:0] r_idx;
    logic [SAMPLE_W-1:0]        r_prev;
    logic [PHASE_W-1:0]         r_phase;

    logic                       accept;
    logic [DIFF_W-1:0]          diff;
    logic [SINE_TABLE_BITS-1:0] cos_idx;

    function automatic t_qval quarter_lookup(logic [SINE_TABLE_BITS-1:0] k);
        logic [QTR_IDX_W-1:0] r;
        logic [QTR_IDX_W-1:0] mirror;
        r      = {1'b0, k[SINE_TABLE_BITS-3:0]};
        mirror = QTR_IDX_W'(QTR_N) - r;
        return k[SINE_TABLE_BITS-2] ? QUARTER_TAB[mirror] : QUARTER_TAB[r];
    endfunction

    assign o_full  = r_valid && i_wq_full;
    assign accept  = i_push && !o_full;
    assign diff    = {i_sample[SAMPLE_W-1], i_sample} - {r_prev[SAMPLE_W-1], r_prev};
    assign cos_idx = r_idx + SINE_TABLE_BITS'(QTR_N);

    assign o_wq_wr = r_valid && !i_wq_full;
    always_comb begin
        o_wq_data.start       = r_start;
        o_wq_data.x_neg       = r_x_neg;
        o_wq_data.x_mag       = r_x_mag;
        o_wq_data.coef_neg[0] = cos_idx[SINE_TABLE_BITS-1];
        o_wq_data.coef_neg[1] = r_idx[SINE_TABLE_BITS-1];
        o_wq_data.coef_mag[0] = quarter_lookup(cos_idx);
        o_wq_data.coef_mag[1] = quarter_lookup(r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
            r_phase <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_start <= i_start_req;
                r_x_neg <= diff[DIFF_W-1];
                r_x_mag <= diff[DIFF_W-1] ? -diff : diff;
                r_idx   <= r_phase[PHASE_W-1 -: SINE_TABLE_BITS];
                r_prev  <= i_sample;
                // a start request restarts the phase one step in
                r_phase <= i_start_req ? i_phase_step : r_phase + i_phase_step;
            end else if (!i_wq_full) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: src/sffe_queue.sv
// Short request queue between the front end and the filter back end.
// Depends on sffe_pkg.
module sffe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  sffe_pkg::t_work i_wdata,
    output logic            o_full,
    input  logic            i_rd,
    output sffe_pkg::t_work o_rdata,
    output logic            o_empty
);
    import sffe_pkg::*;

    t_work               r_mem [WQ_DEPTH];
    logic [WQ_PTR_W:0]   r_wr_ptr;
    logic [WQ_PTR_W:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[WQ_PTR_W] != r_rd_ptr[WQ_PTR_W])
                  && (r_wr_ptr[WQ_PTR_W-1:0] == r_rd_ptr[WQ_PTR_W-1:0]);
    assign o_rdata = r_mem[r_rd_ptr[WQ_PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wr_ptr[WQ_PTR_W-1:0]] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

// File: src/sffe_back.sv
// Back end: complex one-pole filter, squared magnitude and bit-serial root.
// Depends on sffe_pkg; takes requests from sffe_queue.
module sffe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sffe_pkg::RADIUS_W-1:0] i_pole_radius,
    input  logic                          i_wq_empty,
    input  sffe_pkg::t_work               i_wq_data,
    output sffe_pkg::t_back_stat          o_stat,
    input  logic                          i_res_pop,
    output logic                          o_res_valid,
    output logic [sffe_pkg::ENV_W-1:0]    o_envelope
);
    import sffe_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RY0, ST_RY1, ST_XC, ST_SUM, ST_MAG,
        ST_SQ0, ST_SQ1, ST_SQ2, ST_ADD, ST_ROOT, ST_DONE
    } t_state;

    t_state                r_state;
    t_work                 r_item;
    logic [FILT_W-1:0]     r_y   [2];
    logic [FILT_W-1:0]     r_mag [2];
    logic [FILT_W-1:0]     r_t   [2];
    logic [SQ_W-1:0]       r_acc [2];
    logic [Z_W-1:0]        r_z;
    logic [REM_W-1:0]      r_rem;
    logic [ENV_W-1:0]      r_root;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic                  r_ovf;
    logic                  r_res_valid;
    logic [ENV_W-1:0]      r_env;

    logic [HALF_W-1:0]     mul_a [2];
    logic [MUL_B_W-1:0]    mul_b [2];
    logic [PROD_W-1:0]     prod  [2];
    logic [SQ_W-1:0]       rnd   [2];
    logic [FILT_W+1:0]     y_sum [2];
    logic [FILT_W-1:0]     y_sat [2];
    logic [FILT_W-1:0]     y_abs [2];
    logic [SQ_W-1:0]       sq_sum;
    logic [SQ_W-1:0]       sq_shift;
    logic                  sq_ovf;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  res_load;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            unique case (r_state)
                ST_RY0: begin
                    mul_a[l] = r_mag[l][HALF_W-1:0];
                    mul_b[l] = MUL_B_W'(i_pole_radius);
                end
                ST_RY1: begin
                    mul_a[l] = r_mag[l][FILT_W-1:HALF_W];
                    mul_b[l] = MUL_B_W'(i_pole_radius);
                end
                ST_XC: begin
                    mul_a[l] = HALF_W'(r_item.x_mag);
                    mul_b[l] = MUL_B_W'(r_item.coef_mag[l]);
                end
                ST_SQ0: begin
                    mul_a[l] = r_mag[l][HALF_W-1:0];
                    mul_b[l] = MUL_B_W'(r_mag[l][HALF_W-1:0]);
                end
                ST_SQ1: begin
                    mul_a[l] = r_mag[l][HALF_W-1:0];
                    mul_b[l] = MUL_B_W'(r_mag[l][FILT_W-1:HALF_W]);
                end
                ST_SQ2: begin
                    mul_a[l] = r_mag[l][FILT_W-1:HALF_W];
                    mul_b[l] = MUL_B_W'(r_mag[l][FILT_W-1:HALF_W]);
                end
                default: begin
                    mul_a[l] = '0;
                    mul_b[l] = '0;
                end
            endcase
            prod[l] = PROD_W'(mul_a[l]) * PROD_W'(mul_b[l]);

            // r*|y| rounded half away from zero; sign is applied below
            rnd[l] = r_acc[l] + (SQ_W'(1) << (RADIUS_W - 1));

            y_sum[l] = (r_y[l][FILT_W-1] ? {2'b00, r_t[l]} : -{2'b00, r_t[l]})
                     + ((r_item.x_neg ^ r_item.coef_neg[l])
                        ? -{2'b00, r_acc[l][FILT_W-1:0]} : {2'b00, r_acc[l][FILT_W-1:0]});
            if (y_sum[l][FILT_W+1:FILT_W-1] == 3'b000 || y_sum[l][FILT_W+1:FILT_W-1] == 3'b111) begin
                y_sat[l] = y_sum[l][FILT_W-1:0];
            end else if (y_sum[l][FILT_W+1]) begin
                y_sat[l] = {1'b1, {(FILT_W-1){1'b0}}};
            end else begin
                y_sat[l] = {1'b0, {(FILT_W-1){1'b1}}};
            end

            y_abs[l] = r_y[l][FILT_W-1] ? -r_y[l] : r_y[l];
        end

        sq_sum   = r_acc[0] + r_acc[1];
        sq_shift = sq_sum >> (2 * FRACTION_BITS);
        sq_ovf   = (sq_shift >> Z_W) != '0;

        rem_sh = {r_rem[REM_W-3:0], r_z[Z_W-1:Z_W-2]};
        trial  = {r_root, 2'b01};
    end

    assign res_load        = (r_state == ST_DONE) && (!r_res_valid || i_res_pop);
    assign o_stat.wq_pop   = (r_state == ST_IDLE) && !i_wq_empty;
    assign o_stat.res_load = res_load;
    assign o_res_valid     = r_res_valid;
    assign o_envelope      = r_env;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
            for (int l = 0; l < 2; l++) begin
                r_y[l]   <= '0;
                r_mag[l] <= '0;
            end
        end else begin
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_wq_empty) begin
                        r_item <= i_wq_data;
                        if (i_wq_data.start) begin
                            for (int l = 0; l < 2; l++) begin
                                r_y[l]   <= '0;
                                r_mag[l] <= '0;
                            end
                            r_ovf   <= 1'b0;
                            r_root  <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RY0;
                        end
                    end
                end
                ST_RY0: begin
                    for (int l = 0; l < 2; l++) r_acc[l] <= SQ_W'(prod[l]);
                    r_state <= ST_RY1;
                end
                ST_RY1: begin
                    for (int l = 0; l < 2; l++) begin
                        r_acc[l] <= r_acc[l] + (SQ_W'(prod[l]) << HALF_W);
                    end
                    r_state <= ST_XC;
                end
                ST_XC: begin
                    for (int l = 0; l < 2; l++) begin
                        r_t[l]   <= rnd[l][RADIUS_W +: FILT_W];
                        r_acc[l] <= SQ_W'(prod[l]);
                    end
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    for (int l = 0; l < 2; l++) r_y[l] <= y_sat[l];
                    r_state <= ST_MAG;
                end
                ST_MAG: begin
                    for (int l = 0; l < 2; l++) r_mag[l] <= y_abs[l];
                    r_state <= ST_SQ0;
                end
                ST_SQ0: begin
                    for (int l = 0; l < 2; l++) r_acc[l] <= SQ_W'(prod[l]);
                    r_state <= ST_SQ1;
                end
                ST_SQ1: begin
                    // cross term counted twice
                    for (int l = 0; l < 2; l++) begin
                        r_acc[l] <= r_acc[l] + (SQ_W'(prod[l]) << (HALF_W + 1));
                    end
                    r_state <= ST_SQ2;
                end
                ST_SQ2: begin
                    for (int l = 0; l < 2; l++) begin
                        r_acc[l] <= r_acc[l] + (SQ_W'(prod[l]) << FILT_W);
                    end
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_z     <= sq_shift[Z_W-1:0];
                    r_ovf   <= sq_ovf;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    r_z <= r_z << 2;
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[ENV_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[ENV_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ROOT_CNT_W'(ENV_W - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (res_load) begin
                        r_env   <= r_ovf ? ENV_MAX : r_root;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/single_frequency_filter_envelope.sv
// Top level of the single-frequency filter envelope block.
// Depends on sffe_pkg, sffe_front, sffe_queue, sffe_back and the defines header.
//
//   channel   direction  handshake          payload
//   input     in         push / full        i_sample, i_start_req
//   result    out        empty / pop        o_envelope
//   config    in         i_cfg_wr_en        i_cfg_index, i_cfg_data
//
// The front end takes one request per cycle, unless full, into a 4-entry queue.
// The back end works on one request at a time: an ordinary sample takes 9 multiply/filter
// steps, 25 square-root steps, pop and hand-off, and a start request only pop and hand-off;
// the one-bit-per-cycle square root is the longest part.
// Synchronous active-low reset, one cycle, no clearing pass.
// A waiting result holds the back end only at its final step.
`include "single_frequency_filter_envelope_defines.svh"

module single_frequency_filter_envelope (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [sffe_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                            i_start_req,
    output logic                            empty,
    input  logic                            pop,
    output logic [sffe_pkg::ENV_W-1:0]      o_envelope,
    input  logic                            i_cfg_wr_en,
    input  logic [sffe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sffe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sffe_pkg::*;

    logic [PHASE_W-1:0]  r_phase_step;
    logic [RADIUS_W-1:0] r_pole_radius;

    logic       wq_wr;
    logic       wq_full;
    logic       wq_empty;
    t_work      wq_wdata;
    t_work      wq_rdata;
    t_back_stat back_stat;
    logic       res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= PHASE_STEP_RST;
            r_pole_radius <= POLE_RADIUS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[PHASE_W-1:0];
                CFG_POLE_RADIUS: r_pole_radius <= i_cfg_data[RADIUS_W-1:0];
                default:         ;
            endcase
        end
    end

    sffe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_phase_step (r_phase_step),
        .i_push       (push),
        .o_full       (full),
        .i_sample     (i_sample),
        .i_start_req  (i_start_req),
        .i_wq_full    (wq_full),
        .o_wq_wr      (wq_wr),
        .o_wq_data    (wq_wdata)
    );

    sffe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wq_wr),
        .i_wdata (wq_wdata),
        .o_full  (wq_full),
        .i_rd    (back_stat.wq_pop),
        .o_rdata (wq_rdata),
        .o_empty (wq_empty)
    );

    sffe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pole_radius (r_pole_radius),
        .i_wq_empty    (wq_empty),
        .i_wq_data     (wq_rdata),
        .o_stat        (back_stat),
        .i_res_pop     (pop),
        .o_res_valid   (res_valid),
        .o_envelope    (o_envelope)
    );

    assign empty = !res_valid;

    `SFFE_ASSERT_NEVER(a_wq_flags, i_clk, i_rst_n, wq_full && wq_empty)
    `SFFE_ASSERT_IMPLY(a_wq_pop_nonempty, i_clk, i_rst_n, back_stat.wq_pop, !wq_empty)
    `SFFE_ASSERT_IMPLY(a_res_no_overwrite, i_clk, i_rst_n, back_stat.res_load, empty || pop)
    `SFFE_ASSERT_IMPLY(a_full_needs_wq_full, i_clk, i_rst_n, full, wq_full)

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for single_frequency_filter_envelope: random and directed sample requests,
// register writes between phases, envelopes predicted by a scoreboard class and checked in order.
// Depends on sffe_pkg and the RTL top level.
module tb;
    import sffe_pkg::*;

    localparam int TAB_N       = 1 << SINE_TABLE_BITS;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 48;
    localparam int PHASE_ITEMS = 110;
    localparam int SAT_ITEMS   = 400;
    localparam longint FILT_HI = 64'sd549755813887;
    localparam longint FILT_LO = -64'sd549755813888;

    class envelope_scoreboard;
        logic [ENV_W-1:0]           envelopes_due[$];
        int unsigned                errors;
        logic [PHASE_W-1:0]         step_reg;
        logic [RADIUS_W-1:0]        radius_reg;
        logic [PHASE_W-1:0]         phase_acc;
        logic signed [SAMPLE_W-1:0] last_sample;
        longint                     y_re;
        longint                     y_im;
        longint                     quarter[0:QTR_N];

        function new();
            for (int i = 0; i <= QTR_N; i++) quarter[i] = taylor_sine(i);
            errors      = 0;
            step_reg    = PHASE_STEP_RST;
            radius_reg  = POLE_RADIUS_RST;
            phase_acc   = '0;
            last_sample = '0;
            y_re        = 0;
            y_im        = 0;
        endfunction

        // sine of the first quadrant in Q30, rounded to QF
        function longint taylor_sine(int unsigned i);
            logic [63:0] ang;
            logic [63:0] ang2;
            logic [63:0] term;
            longint      acc;
            ang  = (PI_Q30 * 64'd2 * 64'(i)) >> SINE_TABLE_BITS;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * ang2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) acc -= longint'(term);
                else acc += longint'(term);
            end
            if (acc < 0) acc = 0;
            return longint'((64'(acc) + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
        endfunction

        function longint sine_of(int unsigned k);
            int unsigned r;
            k = k & (TAB_N - 1);
            r = k & (TAB_N / 4 - 1);
            case (k >> (SINE_TABLE_BITS - 2))
                0: return quarter[r];
                1: return quarter[TAB_N / 4 - r];
                2: return -quarter[r];
                default: return -quarter[TAB_N / 4 - r];
            endcase
        endfunction

        // -r*y, magnitude rounded half away from zero
        function longint pole_feedback(longint y);
            logic [63:0] mag;
            logic [63:0] t;
            mag = (y < 0) ? 64'(-y) : 64'(y);
            t   = (mag * 64'(radius_reg) + 64'd16384) >> 15;
            return (y < 0) ? longint'(t) : -longint'(t);
        endfunction

        function longint clip40(longint v);
            if (v > FILT_HI) return FILT_HI;
            if (v < FILT_LO) return FILT_LO;
            return v;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] bitv;
            root = '0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        function logic [ENV_W-1:0] envelope_of();
            logic [127:0] a;
            logic [127:0] b;
            logic [127:0] z;
            logic [63:0]  root;
            a = 128'(y_re < 0 ? -y_re : y_re);
            b = 128'(y_im < 0 ? -y_im : y_im);
            z = (a * a + b * b) >> (2 * FRACTION_BITS);
            // beyond any sum of two 40-bit squares
            if (z >= (128'd1 << 50)) return ENV_MAX;
            root = int_sqrt(z[63:0]);
            return (root > 64'(ENV_MAX)) ? ENV_MAX : root[ENV_W-1:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PHASE_STEP) step_reg = data[PHASE_W-1:0];
            else if (idx == CFG_POLE_RADIUS) radius_reg = data[RADIUS_W-1:0];
        endfunction

        function void log_sample(logic [SAMPLE_W-1:0] s, logic st);
            longint           diff;
            longint           c;
            longint           sn;
            int unsigned      idx;
            logic [ENV_W-1:0] env;
            if (st) begin
                last_sample   = s;
                phase_acc     = step_reg;
                y_re          = 0;
                y_im          = 0;
                env           = '0;
                envelopes_due = {envelopes_due, env};
                return;
            end
            diff        = longint'($signed(s)) - longint'(last_sample);
            last_sample = s;
            idx         = phase_acc >> (PHASE_W - SINE_TABLE_BITS);
            c           = sine_of(idx + TAB_N / 4);
            sn          = sine_of(idx);
            phase_acc   = phase_acc + step_reg;
            y_re        = clip40(pole_feedback(y_re) + diff * c);
            y_im        = clip40(pole_feedback(y_im) + diff * sn);
            env           = envelope_of();
            envelopes_due = {envelopes_due, env};
        endfunction

        task flag_mismatch(string msg);
            $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_envelope(logic [ENV_W-1:0] got);
            logic [ENV_W-1:0] want;
            if (envelopes_due.size() == 0) begin
                flag_mismatch($sformatf("envelope %0d with no request pending", got));
                return;
            end
            want = envelopes_due.pop_front();
            if (got !== want)
                flag_mismatch($sformatf("envelope %0d, predicted %0d", got, want));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  i_start_req;
    logic                  empty;
    logic                  pop;
    logic [ENV_W-1:0]      o_envelope;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  no_idle = 1'b0;

    envelope_scoreboard sb = new();

    single_frequency_filter_envelope DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_sample    (i_sample),
        .i_start_req (i_start_req),
        .empty       (empty),
        .pop         (pop),
        .o_envelope  (o_envelope),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic st);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_sample    <= s;
        i_start_req <= st;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.log_sample(s, st);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.envelopes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [PHASE_W-1:0] ph_step, input logic [RADIUS_W-1:0] radius);
        logic [CFG_DATA_W-1:0] rdata;
        // junk above the radius field must be dropped
        rdata = {(CFG_DATA_W - RADIUS_W)'($urandom), radius};
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_PHASE_STEP;
        i_cfg_data  <= ph_step;
        @(posedge i_clk);
        sb.write_reg(CFG_PHASE_STEP, ph_step);
        i_cfg_index <= CFG_POLE_RADIUS;
        i_cfg_data  <= rdata;
        @(posedge i_clk);
        sb.write_reg(CFG_POLE_RADIUS, rdata);
        i_cfg_wr_en <= 1'b0;
    endtask

    // runs of samples, most opened by a start request
    task automatic random_phase(input int n_items);
        int                  sent;
        int                  seg_len;
        int                  flavor;
        logic [SAMPLE_W-1:0] s;
        logic                st;
        sent = 0;
        s    = '0;
        while (sent < n_items) begin
            seg_len = $urandom_range(4, 40);
            flavor  = $urandom_range(0, 3);
            for (int j = 0; j < seg_len && sent < n_items; j++) begin
                case (flavor)
                    0: s = SAMPLE_W'($urandom);
                    1: s = s + SAMPLE_W'($urandom_range(0, 1024)) - SAMPLE_W'(512);
                    2: s = j[0] ? 16'h8000 : 16'h7FFF;
                    default: s = SAMPLE_W'($urandom_range(0, 15)) - SAMPLE_W'(8);
                endcase
                st = (j == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 39) == 0);
                send_sample(s, st);
                sent++;
            end
        end
    endtask

    initial begin
        logic [PHASE_W-1:0]  ph_step;
        logic [RADIUS_W-1:0] radius;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_sample    <= '0;
        i_start_req <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_PHASE_STEP;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers, no start yet: recurrence from zero state
        send_sample(16'd1000, 1'b0);
        send_sample(-16'sd1000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        // start clears state, then full-scale swings
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        // back-to-back starts
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0001, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd12345, 1'b0);
        send_sample(-16'sd12345, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);

        for (int p = 0; p < 5; p++) begin
            drain();
            case (p)
                0: begin
                    ph_step = 32'hFFFF_FFFF;
                    radius  = '0;
                end
                1: begin
                    ph_step = $urandom;
                    radius  = RADIUS_W'($urandom_range(0, 32767));
                end
                2: begin
                    ph_step = 32'h8000_0000;
                    radius  = 15'h7FFF;
                end
                3: begin
                    ph_step = '0;
                    radius  = RADIUS_W'($urandom_range(0, 32767));
                end
                default: begin
                    ph_step = $urandom_range(1, 1 << 24);
                    radius  = RADIUS_W'($urandom_range(30000, 32767));
                end
            endcase
            write_regs(ph_step, radius);
            no_idle = (p == 1) || ($urandom_range(0, 3) == 0);
            random_phase(PHASE_ITEMS);
        end

        // fixed cosine, pole at the edge: alternating full scale drives the filter into clipping
        drain();
        write_regs('0, 15'h7FFF);
        no_idle = 1'b0;
        send_sample(16'h7FFF, 1'b1);
        for (int j = 0; j < SAT_ITEMS; j++) send_sample(j[0] ? 16'h7FFF : 16'h8000, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // result side; one long hold-off lets the block back up onto its input
    initial begin
        int taken;
        int gap;
        taken = 0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = (taken == HOLD_AT) ? HOLD_CYCLES : pick_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            sb.check_envelope(o_envelope);
            taken++;
        end
    end

    initial begin
        #6_400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/sffe_pkg.sv
src/sffe_front.sv
src/sffe_queue.sv
src/sffe_back.sv
src/single_frequency_filter_envelope.sv
bench/tb.sv
